FILE: src/nsv_pkg.sv
// Shared types and codes for the numeric string validator.
package nsv_pkg;

    // Target type codes carried on the selector of the first transfer of a string
    localparam logic [3:0] TY_BOOL   = 4'd0;
    localparam logic [3:0] TY_FLOAT  = 4'd1;
    localparam logic [3:0] TY_DOUBLE = 4'd2;
    localparam logic [3:0] TY_LONG   = 4'd3;
    localparam logic [3:0] TY_U64    = 4'd4;
    localparam logic [3:0] TY_I64    = 4'd5;
    localparam logic [3:0] TY_U32    = 4'd6;
    localparam logic [3:0] TY_I32    = 4'd7;
    localparam logic [3:0] TY_U16    = 4'd8;
    localparam logic [3:0] TY_I16    = 4'd9;
    localparam logic [3:0] TY_U8     = 4'd10;
    localparam logic [3:0] TY_I8     = 4'd11;
    localparam logic [3:0] TY_ALNUM  = 4'd12;

    localparam int unsigned CNT_W = 5;
    localparam logic [CNT_W-1:0] COUNT_SAT = 5'd21;

    typedef enum logic [6:0] {
        PH_START    = 7'b0000001,
        PH_WS       = 7'b0000010,
        PH_SIGN     = 7'b0000100,
        PH_BODY     = 7'b0001000,
        PH_EXP_MARK = 7'b0010000,
        PH_EXP_SIGN = 7'b0100000,
        PH_EXP_DIG  = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_LT = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

    typedef struct packed {
        logic [3:0]       str_type;
        phase_t           phase;
        logic             neg;
        logic [CNT_W-1:0] cnt;
        cmp_t             cmp;
        logic             seen_digit;
        logic             seen_point;
        logic             failed;
    } nsv_state_t;

endpackage

FILE: src/numeric_string_validator_top.sv
// Top level of the numeric string validator: input register, parser state, result register.
//
//  channel | dir | tdata           | tuser                        | tlast
//  s_      | in  | [7:0] ch        | [3:0] func, [4] has_char     | last of string
//  m_      | out | [0] valid_res   | -                            | -
//
// One byte per cycle, unless a last-of-string byte waits on a stalled result; each transfer
// is held in the input register and the parser update then writes the state and, on the last
// byte, the result register. Reset (aresetn low, synchronous) empties both registers and
// returns the parser to the start of a string. A stalled result holds back only the next
// last-of-string byte.
module numeric_string_validator_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic [4:0] s_tuser,   // [3:0] func, [4] has_char
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);
    import nsv_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic [3:0] in_func_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    nsv_state_t state_reg;
    nsv_state_t state_next;
    nsv_state_t parse_next;
    logic       verdict;

    logic m_valid_reg;
    logic m_res_reg;
    logic fire;

    // Advance when the byte needs no result slot or the slot is free this cycle
    assign fire     = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg   <= s_tdata;
            in_func_reg <= s_tuser[3:0];
            in_has_reg  <= s_tuser[4];
            in_last_reg <= s_tlast;
        end
    end

    nsv_parse u_parse (
        .cur_state  (state_reg),
        .func       (in_func_reg),
        .has_char   (in_has_reg),
        .ch         (in_ch_reg),
        .next_state (parse_next),
        .verdict    (verdict)
    );

    always_comb begin
        state_next = parse_next;
        if (in_last_reg) state_next.phase = PH_START;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.str_type   <= TY_BOOL;
            state_reg.phase      <= PH_START;
            state_reg.neg        <= 1'b0;
            state_reg.cnt        <= '0;
            state_reg.cmp        <= CMP_EQ;
            state_reg.seen_digit <= 1'b0;
            state_reg.seen_point <= 1'b0;
            state_reg.failed     <= 1'b0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last_reg) m_res_reg <= verdict;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_res_reg};

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> m_valid_reg)
        else $error("no result after last byte");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> state_reg.phase == PH_START)
        else $error("parser not back at string start");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.cnt <= COUNT_SAT)
        else $error("digit count beyond saturation");

    a_failed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !in_last_reg && state_reg.phase != PH_START && state_reg.failed
        |=> state_reg.failed)
        else $error("failure flag dropped mid-string");

endmodule

FILE: src/nsv_parse.sv
// Per-byte parser update and end-of-string verdict.
module nsv_parse (
    input  nsv_pkg::nsv_state_t cur_state,
    input  logic [3:0]          func,
    input  logic                has_char,
    input  logic [7:0]          ch,
    output nsv_pkg::nsv_state_t next_state,
    output logic                verdict
);
    import nsv_pkg::*;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_EXP_UP = 8'h45;
    localparam logic [7:0] CH_EXP_LO = 8'h65;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
        return (n < COUNT_SAT) ? n + 1'b1 : n;
    endfunction

    function automatic logic [CNT_W-1:0] bound_len(input logic [3:0] k);
        logic [CNT_W-1:0] len;
        case (k)
            4'd0, 4'd2: len = 5'd19;
            4'd1:       len = 5'd20;
            4'd3, 4'd4: len = 5'd10;
            4'd5, 4'd6: len = 5'd5;
            4'd7, 4'd8: len = 5'd3;
            default:    len = '0;
        endcase
        return len;
    endfunction

    // Bound digits, most significant first, left aligned in BCD
    function automatic logic [3:0] bound_digit(input logic [3:0] k, input logic neg,
                                               input logic [CNT_W-1:0] idx);
        logic [79:0] b;
        logic [79:0] sh;
        case (k)
            4'd0, 4'd2: b = neg ? 80'h92233720368547758080 : 80'h92233720368547758070;
            4'd1:       b = 80'h18446744073709551615;
            4'd3:       b = 80'h42949672950000000000;
            4'd4:       b = neg ? 80'h21474836480000000000 : 80'h21474836470000000000;
            4'd5:       b = 80'h65535000000000000000;
            4'd6:       b = neg ? 80'h32768000000000000000 : 80'h32767000000000000000;
            4'd7:       b = 80'h25500000000000000000;
            4'd8:       b = neg ? 80'h12800000000000000000 : 80'h12700000000000000000;
            default:    b = '0;
        endcase
        sh = b << {idx, 2'b00};
        return sh[79:76];
    endfunction

    nsv_state_t st;
    nsv_state_t nxt;
    logic [3:0] k;
    logic [3:0] bdig;
    logic [CNT_W-1:0] len;
    logic is_sign;

    always_comb begin
        st = cur_state;
        // Latch the type and clear the parse state on the first transfer of a string
        if (cur_state.phase == PH_START) begin
            st.str_type   = func;
            st.phase      = PH_WS;
            st.neg        = 1'b0;
            st.cnt        = '0;
            st.cmp        = CMP_EQ;
            st.seen_digit = 1'b0;
            st.seen_point = 1'b0;
            st.failed     = 1'b0;
        end
        nxt     = st;
        k       = st.str_type - 4'd3;
        len     = bound_len(k);
        bdig    = bound_digit(k, st.neg, st.cnt);
        is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);

        if (has_char && !st.failed) begin
            case (st.str_type)
                TY_BOOL: begin
                    nxt.cnt = sat_inc(st.cnt);
                    if (ch != CH_ZERO && ch != CH_ONE) nxt.failed = 1'b1;
                end
                TY_ALNUM: begin
                    nxt.cnt = sat_inc(st.cnt);
                    if (!is_dig(ch) && !is_letter(ch)) nxt.failed = 1'b1;
                end
                TY_FLOAT, TY_DOUBLE: begin
                    if (st.phase == PH_WS && is_ws(ch)) begin
                        nxt.phase = PH_WS;
                    end else if (st.phase == PH_WS && is_sign) begin
                        nxt.phase = PH_SIGN;
                    end else if (st.phase == PH_WS || st.phase == PH_SIGN
                                 || st.phase == PH_BODY) begin
                        if (is_dig(ch)) begin
                            nxt.seen_digit = 1'b1;
                            nxt.phase      = PH_BODY;
                        end else if (ch == CH_POINT && !st.seen_point) begin
                            nxt.seen_point = 1'b1;
                            nxt.phase      = PH_BODY;
                        end else if ((ch == CH_EXP_LO || ch == CH_EXP_UP) && st.seen_digit) begin
                            // Exponent needs digits of its own
                            nxt.seen_digit = 1'b0;
                            nxt.phase      = PH_EXP_MARK;
                        end else begin
                            nxt.failed = 1'b1;
                        end
                    end else if (st.phase == PH_EXP_MARK && is_sign) begin
                        nxt.phase = PH_EXP_SIGN;
                    end else if (is_dig(ch)) begin
                        nxt.seen_digit = 1'b1;
                        nxt.phase      = PH_EXP_DIG;
                    end else begin
                        nxt.failed = 1'b1;
                    end
                end
                TY_LONG, TY_U64, TY_I64, TY_U32, TY_I32, TY_U16, TY_I16, TY_U8, TY_I8: begin
                    if (st.phase == PH_WS && is_ws(ch)) begin
                        nxt.phase = PH_WS;
                    end else if (st.phase == PH_WS && ch == CH_PLUS) begin
                        nxt.phase = PH_SIGN;
                    end else if (st.phase == PH_WS && ch == CH_MINUS) begin
                        // Even bound slots are the signed types
                        if (!k[0]) begin
                            nxt.neg   = 1'b1;
                            nxt.phase = PH_SIGN;
                        end else begin
                            nxt.failed = 1'b1;
                        end
                    end else if (!is_dig(ch)) begin
                        nxt.failed = 1'b1;
                    end else begin
                        nxt.phase      = PH_BODY;
                        nxt.seen_digit = 1'b1;
                        if (st.cnt < len && st.cmp == CMP_EQ) begin
                            if (ch[3:0] < bdig) nxt.cmp = CMP_LT;
                            else if (ch[3:0] > bdig) nxt.cmp = CMP_GT;
                        end
                        nxt.cnt = sat_inc(st.cnt);
                    end
                end
                default: nxt.failed = 1'b1;
            endcase
        end

        verdict = 1'b0;
        if (!nxt.failed) begin
            case (nxt.str_type)
                TY_BOOL:             verdict = (nxt.cnt == 5'd1);
                TY_ALNUM:            verdict = (nxt.cnt != '0);
                TY_FLOAT, TY_DOUBLE: verdict = nxt.seen_digit;
                TY_LONG, TY_U64, TY_I64, TY_U32, TY_I32, TY_U16, TY_I16, TY_U8, TY_I8:
                    verdict = nxt.seen_digit
                              && ((nxt.cnt < len) || (nxt.cnt == len && nxt.cmp != CMP_GT));
                default:             verdict = 1'b0;
            endcase
        end

        next_state = nxt;
    end

endmodule
